// File: design/ata_pkg.sv
`timescale 1ns / 1ps
package ata_pkg;

  // table of atan(2^-i), units of 2^-30 rad
  localparam int TableStages = 24;
  localparam int AngleLimit  = 25736;

  // widths of the angle datapath
  localparam int DiffW = 17;          // offset-corrected count
  localparam int SumW  = 34;          // a^2 + b^2
  localparam int RadW  = 29;          // isqrt(sum << 24) < 2^29
  localparam int CxW   = 32;          // cordic x/y width
  localparam int CzW   = 33;          // cordic angle accumulator

  // register indexes
  localparam logic [1:0] RegOffsetX = 2'd0;
  localparam logic [1:0] RegOffsetY = 2'd1;
  localparam logic [1:0] RegOffsetZ = 2'd2;

  function automatic logic signed [CzW-1:0] atan_lut(input int unsigned i);
    logic signed [CzW-1:0] v;
    v = '0;
    unique case (i)
      0:  v = 33'sh03243F6A8;
      1:  v = 33'sh01DAC6705;
      2:  v = 33'sh00FADBAFC;
      3:  v = 33'sh007F56EA6;
      4:  v = 33'sh003FEAB76;
      5:  v = 33'sh001FFD55B;
      6:  v = 33'sh000FFFAAA;
      7:  v = 33'sh0007FFF55;
      8:  v = 33'sh0003FFFEA;
      9:  v = 33'sh0001FFFFD;
      10: v = 33'sh0000FFFFF;
      11: v = 33'sh00007FFFF;
      12: v = 33'sh00003FFFF;
      13: v = 33'sh00001FFFF;
      14: v = 33'sh00000FFFF;
      15: v = 33'sh000007FFF;
      16: v = 33'sh000003FFF;
      17: v = 33'sh000001FFF;
      18: v = 33'sh000000FFF;
      19: v = 33'sh0000007FF;
      20: v = 33'sh0000003FF;
      21: v = 33'sh0000001FF;
      22: v = 33'sh0000000FF;
      23: v = 33'sh00000007F;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// File: design/ata_if.sv
`timescale 1ns / 1ps
interface ata_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] raw_x;
  logic signed [15:0] raw_y;
  logic signed [15:0] raw_z;
  modport source (output valid, raw_x, raw_y, raw_z, input ready);
  modport sink   (input valid, raw_x, raw_y, raw_z, output ready);
endinterface

interface ata_out_if;
  logic               valid;
  logic               ready;
  logic signed [18:0] accel_x_mg;
  logic signed [18:0] accel_y_mg;
  logic signed [18:0] accel_z_mg;
  logic signed [15:0] pitch;
  logic signed [15:0] roll;
  modport source (output valid, accel_x_mg, accel_y_mg, accel_z_mg, pitch, roll,
                  input ready);
  modport sink   (input valid, accel_x_mg, accel_y_mg, accel_z_mg, pitch, roll,
                  output ready);
endinterface

// File: design/ata_sqrt.sv
`timescale 1ns / 1ps
// Pipelined restoring square root of (sum << 24): one result bit per stage.
// Carries a side payload of numerator and zero flag along.
module ata_sqrt
  import ata_pkg::*;
#(
  parameter int SideW = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [SumW-1:0]   in_sum,
  input  logic [SideW-1:0]  in_side,
  output logic              out_vld,
  output logic [RadW-1:0]   out_root,
  output logic [SideW-1:0]  out_side
);

  localparam int RemW = RadW + 2;
  localparam int OpW  = 2 * RadW;

  logic [RadW:0]             vld_r;
  logic [OpW-1:0]            op_r   [RadW+1];
  logic [RemW-1:0]           rem_r  [RadW+1];
  logic [RadW-1:0]           root_r [RadW+1];
  logic [SideW-1:0]          side_r [RadW+1];

  // load operand
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op_r[0]   <= {in_sum[OpW-25:0], 24'd0};
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      side_r[0] <= in_side;
    end
  end

  // one root bit per stage, two operand bits consumed
  for (genvar s = 0; s < RadW; s++) begin : g_stage
    logic [RemW-1:0] rem_sh;
    logic [RemW-1:0] trial;
    always_comb begin
      rem_sh = {rem_r[s][RemW-3:0], op_r[s][OpW-1:OpW-2]};
      trial  = {root_r[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s+1] <= 1'b0;
      end else if (en) begin
        vld_r[s+1] <= vld_r[s];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        op_r[s+1]   <= {op_r[s][OpW-3:0], 2'b00};
        side_r[s+1] <= side_r[s];
        if (rem_sh >= trial) begin
          rem_r[s+1]  <= rem_sh - trial;
          root_r[s+1] <= {root_r[s][RadW-2:0], 1'b1};
        end else begin
          rem_r[s+1]  <= rem_sh;
          root_r[s+1] <= {root_r[s][RadW-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld  = vld_r[RadW];
  assign out_root = root_r[RadW];
  assign out_side = side_r[RadW];

endmodule

// File: design/ata_cordic.sv
`timescale 1ns / 1ps
// Vectoring rotation pipeline: one micro-rotation per stage, then round,
// optional negate and saturate.
module ata_cordic
  import ata_pkg::*;
#(
  parameter int Stages = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_vld,
  input  logic [RadW-1:0]         in_root,
  input  logic signed [DiffW-1:0] in_num,
  input  logic                    in_zero,
  input  logic                    in_neg,
  output logic                    out_vld,
  output logic signed [15:0]      out_angle
);

  localparam int NStg = (Stages < TableStages) ? Stages : TableStages;

  logic [NStg:0]         vld_r;
  logic signed [CxW-1:0] x_r [NStg+1];
  logic signed [CxW-1:0] y_r [NStg+1];
  logic signed [CzW-1:0] z_r [NStg+1];
  logic [NStg:0]         zero_r;
  logic [NStg:0]         neg_r;
  logic                  ovld_r;
  logic signed [15:0]    angle_r;

  // load start vector (R, N * 2^12, 0)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= CxW'($signed({1'b0, in_root}));
      y_r[0]    <= CxW'($signed({in_num, 12'd0}));
      z_r[0]    <= '0;
      zero_r[0] <= in_zero;
      neg_r[0]  <= in_neg;
    end
  end

  for (genvar i = 0; i < NStg; i++) begin : g_rot
    localparam logic signed [CzW-1:0] Ang = atan_lut(i);
    logic signed [CxW-1:0] xs;
    logic signed [CxW-1:0] ys;
    always_comb begin
      xs = x_r[i] >>> i;
      ys = y_r[i] >>> i;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        neg_r[i+1]  <= neg_r[i];
        if (!y_r[i][CxW-1]) begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + Ang;
        end else begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - Ang;
        end
      end
    end
  end

  // round half up, negate, clamp to +-pi/2
  logic signed [CzW-1:0] rnd;
  logic signed [17:0]    q;
  logic signed [17:0]    v;
  logic signed [15:0]    angle_nxt;
  always_comb begin
    rnd = (z_r[NStg] + CzW'(33'sd32768)) >>> 16;
    q   = 18'(rnd);
    v   = neg_r[NStg] ? -q : q;
    if (zero_r[NStg]) begin
      angle_nxt = '0;
    end else if (v > 18'(AngleLimit)) begin
      angle_nxt = 16'(AngleLimit);
    end else if (v < -18'(AngleLimit)) begin
      angle_nxt = -16'(AngleLimit);
    end else begin
      angle_nxt = v[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovld_r <= 1'b0;
    end else if (en) begin
      ovld_r <= vld_r[NStg];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= angle_nxt;
    end
  end

  assign out_vld   = ovld_r;
  assign out_angle = angle_r;

endmodule

// File: design/accel_tilt_angles.sv
`timescale 1ns / 1ps
// Channel | Dir | Fields
// in_     | in  | raw_x, raw_y, raw_z (s16)
// out_    | out | accel_x_mg, accel_y_mg, accel_z_mg (s19), pitch, roll (s16 Q2.14)
// cfg_    | in  | cfg_we, cfg_idx, cfg_data: offset_x/y/z
//
// One word accepted per cycle while the output is not stalled; each word passes offset
// correction, squares, the square root and up to 24 micro-rotations, then the output
// register. The whole pipeline advances when the output register is empty or taken, so a
// stall freezes every stage and drops nothing. Reset clears valid bits and offsets.
module accel_tilt_angles
  import ata_pkg::*;
#(
  parameter int ROTATION_STAGES = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  ata_in_if.sink       in_ch,
  ata_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_idx,
  input  logic [15:0]  cfg_data
);

  localparam int SqLat = RadW + 1;
  localparam int NStg  = (ROTATION_STAGES < TableStages) ? ROTATION_STAGES : TableStages;
  localparam int Lat   = 1 + SqLat + NStg + 2;
  localparam int SideW = DiffW + 1;

  logic signed [15:0] off_x_r, off_y_r, off_z_r;
  logic               en;

  // write offsets
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegOffsetX: off_x_r <= cfg_data;
        RegOffsetY: off_y_r <= cfg_data;
        RegOffsetZ: off_z_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // stage 0: offset correction
  logic                    s0_vld_r;
  logic signed [DiffW-1:0] dx_r, dy_r, dz_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else if (en) begin
      s0_vld_r <= in_ch.valid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= DiffW'(in_ch.raw_x) - DiffW'(off_x_r);
      dy_r <= DiffW'(in_ch.raw_y) - DiffW'(off_y_r);
      dz_r <= DiffW'(in_ch.raw_z) - DiffW'(off_z_r);
    end
  end

  // stage 1: squares and sums
  logic                    s1_vld_r;
  logic [SumW-1:0]         sp_r, sr_r;
  logic signed [DiffW-1:0] s1x_r, s1y_r;
  logic [SumW-1:0]         sqx, sqy, sqz;
  always_comb begin
    sqx = SumW'(unsigned'(SumW'(dx_r) * SumW'(dx_r)));
    sqy = SumW'(unsigned'(SumW'(dy_r) * SumW'(dy_r)));
    sqz = SumW'(unsigned'(SumW'(dz_r) * SumW'(dz_r)));
  end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= s0_vld_r;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sp_r  <= sqx + sqz;
      sr_r  <= sqy + sqz;
      s1x_r <= dx_r;
      s1y_r <= dy_r;
    end
  end

  // delay line for milli-g outputs, aligned to the angle result
  logic signed [DiffW-1:0] dlx_r [Lat], dly_r [Lat], dlz_r [Lat];
  always_ff @(posedge clk) begin
    if (en) begin
      dlx_r[0] <= dx_r;
      dly_r[0] <= dy_r;
      dlz_r[0] <= dz_r;
      for (int k = 1; k < Lat; k++) begin
        dlx_r[k] <= dlx_r[k-1];
        dly_r[k] <= dly_r[k-1];
        dlz_r[k] <= dlz_r[k-1];
      end
    end
  end

  // square roots (pitch uses x,z; roll uses y,z)
  logic            qp_vld, qr_vld;
  logic [RadW-1:0] rp, rr;
  logic [SideW-1:0] sdp, sdr;
  ata_sqrt #(.SideW(SideW)) u_sq_p (
    .clk, .rst_n, .en, .in_vld(s1_vld_r), .in_sum(sp_r),
    .in_side({s1y_r, (s1y_r == '0) && (sp_r == '0)}),
    .out_vld(qp_vld), .out_root(rp), .out_side(sdp)
  );
  ata_sqrt #(.SideW(SideW)) u_sq_r (
    .clk, .rst_n, .en, .in_vld(s1_vld_r), .in_sum(sr_r),
    .in_side({s1x_r, (s1x_r == '0) && (sr_r == '0)}),
    .out_vld(qr_vld), .out_root(rr), .out_side(sdr)
  );

  logic               cp_vld, cr_vld;
  logic signed [15:0] pitch_w, roll_w;
  ata_cordic #(.Stages(ROTATION_STAGES)) u_cor_p (
    .clk, .rst_n, .en, .in_vld(qp_vld), .in_root(rp),
    .in_num(sdp[SideW-1:1]), .in_zero(sdp[0]), .in_neg(1'b0),
    .out_vld(cp_vld), .out_angle(pitch_w)
  );
  ata_cordic #(.Stages(ROTATION_STAGES)) u_cor_r (
    .clk, .rst_n, .en, .in_vld(qr_vld), .in_root(rr),
    .in_num(sdr[SideW-1:1]), .in_zero(sdr[0]), .in_neg(1'b1),
    .out_vld(cr_vld), .out_angle(roll_w)
  );

  assign out_ch.valid      = cp_vld && cr_vld;
  assign out_ch.pitch      = pitch_w;
  assign out_ch.roll       = roll_w;
  assign out_ch.accel_x_mg = {dlx_r[Lat-1], 2'b00};
  assign out_ch.accel_y_mg = {dly_r[Lat-1], 2'b00};
  assign out_ch.accel_z_mg = {dlz_r[Lat-1], 2'b00};

endmodule

// File: dv/tb_accel_tilt_angles.sv
`timescale 1ns / 1ps
module tb_accel_tilt_angles;
  import ata_pkg::*;

  localparam int Stages  = 16;
  localparam int Latency = 2 + 30 + Stages + 2;

  typedef struct packed {
    logic signed [18:0] ax;
    logic signed [18:0] ay;
    logic signed [18:0] az;
    logic signed [15:0] pitch;
    logic signed [15:0] roll;
  } tilt_word_t;

  // Predict tilt words from accepted samples and check them in order
  class tilt_scoreboard;
    logic signed [15:0] off_x, off_y, off_z;
    tilt_word_t pending[$];
    int errors;

    function new();
      off_x = 0; off_y = 0; off_z = 0; errors = 0;
    endfunction

    function automatic longint isqrt(longint unsigned v);
      longint unsigned res, bit_v;
      res = 0;
      bit_v = 64'd1 << 62;
      while (bit_v > v) bit_v >>= 2;
      while (bit_v != 0) begin
        if (v >= res + bit_v) begin
          v -= res + bit_v;
          res = (res >> 1) + bit_v;
        end else begin
          res >>= 1;
        end
        bit_v >>= 2;
      end
      return longint'(res);
    endfunction

    // atan2(num, hypot(a, b)) in Q2.14, before saturation
    function automatic longint angle(longint num, longint a, longint b);
      longint sum, x, y, z, xs, ys;
      sum = a * a + b * b;
      z = 0;
      if (num == 0 && sum == 0) return 0;
      x = isqrt(longint'(sum) << 24);
      y = num * 4096;
      for (int i = 0; i < Stages && i < TableStages; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys; y = y - xs; z += longint'(atan_lut(i));
        end else begin
          x = x - ys; y = y + xs; z -= longint'(atan_lut(i));
        end
      end
      return (z + 32768) >>> 16;
    endfunction

    function automatic longint clamp(longint v);
      if (v > AngleLimit) return AngleLimit;
      if (v < -AngleLimit) return -AngleLimit;
      return v;
    endfunction

    function void note_sample(logic signed [15:0] rx, ry, rz);
      longint dx, dy, dz;
      tilt_word_t w;
      dx = longint'(rx) - longint'(off_x);
      dy = longint'(ry) - longint'(off_y);
      dz = longint'(rz) - longint'(off_z);
      w.ax = 19'(dx * 4);
      w.ay = 19'(dy * 4);
      w.az = 19'(dz * 4);
      w.pitch = 16'(clamp(angle(dy, dx, dz)));
      w.roll = 16'(clamp(-angle(dx, dy, dz)));
      pending.push_back(w);
    endfunction

    function void check_word(tilt_word_t got);
      tilt_word_t exp_w;
      if (pending.size() == 0) begin
        $error("unexpected output word");
        errors++;
        return;
      end
      exp_w = pending.pop_front();
      if (got.ax !== exp_w.ax) begin
        $error("accel_x_mg exp %0d got %0d", exp_w.ax, got.ax); errors++;
      end
      if (got.ay !== exp_w.ay) begin
        $error("accel_y_mg exp %0d got %0d", exp_w.ay, got.ay); errors++;
      end
      if (got.az !== exp_w.az) begin
        $error("accel_z_mg exp %0d got %0d", exp_w.az, got.az); errors++;
      end
      if (got.pitch !== exp_w.pitch) begin
        $error("pitch exp %0d got %0d", exp_w.pitch, got.pitch); errors++;
      end
      if (got.roll !== exp_w.roll) begin
        $error("roll exp %0d got %0d", exp_w.roll, got.roll); errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_idx = RegOffsetX;
  logic [15:0] cfg_data = 0;
  bit quiet = 0;
  bit hold_off = 0;
  tilt_scoreboard sb = new();

  ata_in_if in_ch();
  ata_out_if out_ch();

  accel_tilt_angles #(.ROTATION_STAGES(Stages)) u_dut (
    .clk, .rst_n, .in_ch, .out_ch, .cfg_we, .cfg_idx, .cfg_data
  );

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  initial begin
    in_ch.valid = 0;
    in_ch.raw_x = 0; in_ch.raw_y = 0; in_ch.raw_z = 0;
    out_ch.ready = 0;
  end

  // Note accepted samples and check output words at the rising edge
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      sb.note_sample(in_ch.raw_x, in_ch.raw_y, in_ch.raw_z);
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_word({out_ch.accel_x_mg, out_ch.accel_y_mg, out_ch.accel_z_mg,
                     out_ch.pitch, out_ch.roll});
  end

  // Drive ready with random stall bursts, or a long hold-off on request
  initial begin
    int n;
    @(negedge clk);
    while (1) begin
      if (hold_off) begin
        out_ch.ready <= 0;
        repeat (200) @(negedge clk);
        hold_off = 0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 0;
        n = $urandom_range(1, 11);
        repeat (n) @(negedge clk);
      end else begin
        out_ch.ready <= 1;
        @(negedge clk);
      end
    end
  end

  task automatic send_sample(logic [15:0] rx, ry, rz);
    int n;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 0;
      n = $urandom_range(1, 11);
      repeat (n) @(negedge clk);
    end
    in_ch.valid <= 1;
    in_ch.raw_x <= rx; in_ch.raw_y <= ry; in_ch.raw_z <= rz;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Drive one register write; the caller drops cfg_we after the last one
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_we <= 1; cfg_idx <= idx; cfg_data <= val;
    @(negedge clk);
  endtask

  // Wait for the pipeline to empty before touching offsets
  task automatic drain();
    in_ch.valid <= 0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (Latency + 4) @(negedge clk);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(0, 8) - 4);
      3: return 16'($urandom_range(0, 600) - 300);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic set_offsets(logic [15:0] ox, oy, oz);
    drain();
    write_reg(RegOffsetX, ox);
    write_reg(RegOffsetY, oy);
    write_reg(RegOffsetZ, oz);
    // index beyond the register list is ignored
    write_reg(2'd3, 16'h1234);
    cfg_we <= 0;
    sb.off_x = ox; sb.off_y = oy; sb.off_z = oz;
  endtask

  initial begin
    logic [15:0] ext[4];
    int ph;
    ext = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};
    repeat (12) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: zero vector, single axes, extremes
    send_sample(0, 0, 0);
    send_sample(100, 0, 0);
    send_sample(0, 100, 0);
    send_sample(0, 0, 100);
    send_sample(-100, 0, 0);
    send_sample(0, -100, 0);
    send_sample(1, 1, 0);
    send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
    send_sample(16'h8000, 16'h8000, 16'h8000);
    send_sample(16'h7FFF, 16'h8000, 16'h5555);
    send_sample(16'hAAAA, 16'h5555, 16'hAAAA);
    foreach (ext[i]) send_sample(ext[i], ext[(i + 1) % 4], ext[(i + 2) % 4]);
    // Extreme offsets: differences reach +-65535
    set_offsets(16'h8000, 16'h7FFF, 16'h8000);
    send_sample(16'h7FFF, 16'h8000, 16'h7FFF);
    send_sample(16'h8000, 16'h7FFF, 16'h8000);
    send_sample(16'h8000, 16'h7FFF, 16'h0000);
    set_offsets(16'h7FFF, 16'h8000, 16'h7FFF);
    send_sample(16'h8000, 16'h7FFF, 16'h8000);
    send_sample(16'h7FFF, 16'h8000, 16'h7FFF);

    // Random phases with changing offsets
    for (ph = 0; ph < 6; ph++) begin
      if (ph == 5) quiet = 1;
      set_offsets(ph == 0 ? 16'h0000 : pick_value(),
                  ph == 0 ? 16'h0000 : pick_value(),
                  ph == 0 ? 16'h0000 : pick_value());
      if (ph == 2) hold_off = 1;
      repeat (320) send_sample(pick_value(), pick_value(), pick_value());
    end
    in_ch.valid <= 0;

    while (sb.pending.size() != 0) @(negedge clk);
    repeat (Latency + 10) @(negedge clk);
    if (sb.errors == 0)
      $display("tb_accel_tilt_angles OK");
    else
      $display("tb_accel_tilt_angles NOT OK");
    $finish;
  end

  initial begin
    #5ms;
    $display("tb_accel_tilt_angles NOT OK");
    $finish;
  end

endmodule
